@@ rtl/dq_pkg.sv @@
// Shared types and constants for the double-ended queue.
package dq_pkg;

  // Default sizes
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed port widths
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 3;

  // Operation codes
  typedef enum logic [MODE_W-1:0] {
    OP_PUSH_BACK   = 3'd0,
    OP_PUSH_FRONT  = 3'd1,
    OP_POP_BACK    = 3'd2,
    OP_POP_FRONT   = 3'd3,
    OP_WRITE_BACK  = 3'd4,
    OP_WRITE_FRONT = 3'd5,
    OP_CLEAR       = 3'd6,
    OP_PEEK        = 3'd7
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOOK,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming beat
    logic exec;   // apply the operation to store and pointers
    logic done;   // present the result beat
  } ctl_cmd_t;

endpackage

@@ rtl/dq_ctrl.sv @@
// Sequencing state machine of the double-ended queue.
module dq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output dq_pkg::ctl_cmd_t  cmd
);

  dq_pkg::state_t state;
  dq_pkg::state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through execute, look-up and result
  always_comb begin
    state_next = state;
    busy       = 1'b0;
    cmd        = '0;
    case (state)
      dq_pkg::ST_IDLE: begin
        if (start) begin
          state_next = dq_pkg::ST_EXEC;
        end
      end
      dq_pkg::ST_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = dq_pkg::ST_LOOK;
      end
      dq_pkg::ST_LOOK: begin
        busy       = 1'b1;
        state_next = dq_pkg::ST_DONE;
      end
      dq_pkg::ST_DONE: begin
        cmd.done   = 1'b1;
        state_next = start ? dq_pkg::ST_EXEC : dq_pkg::ST_IDLE;
      end
      default: begin
        state_next = dq_pkg::ST_IDLE;
      end
    endcase
    cmd.load = start && !busy;
  end

endmodule

@@ rtl/dq_datapath.sv @@
// Ring store, pointers and result registers of the double-ended queue.
module dq_datapath #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dq_pkg::ctl_cmd_t            cmd,
  input  logic [dq_pkg::MODE_W-1:0]   mode,
  input  logic [dq_pkg::WORD_W-1:0]   value,
  output logic [dq_pkg::WORD_W-1:0]   popped_value,
  output logic [dq_pkg::STATUS_W-1:0] status,
  output logic [dq_pkg::COUNT_W-1:0]  count,
  output logic [dq_pkg::WORD_W-1:0]   front_value,
  output logic [dq_pkg::WORD_W-1:0]   back_value
);

  localparam int SW = (DATA_WIDTH < dq_pkg::WORD_W) ? DATA_WIDTH : dq_pkg::WORD_W;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [SW-1:0] mem [DEPTH];

  dq_pkg::mode_t   op;
  logic [SW-1:0]   wdata;
  logic [PW-1:0]   fp;
  logic [PW-1:0]   bp;
  logic [CW-1:0]   cnt;
  logic [SW-1:0]   rd_f;
  logic [SW-1:0]   rd_b;
  logic [SW-1:0]   popped;
  dq_pkg::status_t stat;

  logic [PW-1:0]   fp_next;
  logic [PW-1:0]   bp_next;
  logic [CW-1:0]   cnt_next;
  logic [SW-1:0]   popped_next;
  dq_pkg::status_t stat_next;
  logic            we;
  logic [PW-1:0]   waddr;
  logic            empty;
  logic            full;
  logic [PW-1:0]   fp_inc;
  logic [PW-1:0]   fp_dec;
  logic [PW-1:0]   bp_inc;
  logic [PW-1:0]   bp_dec;

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= dq_pkg::mode_t'(mode);
      wdata <= value[SW-1:0];
    end
  end

  // Ring neighbors of both ends
  assign fp_inc = (fp == LAST) ? '0 : fp + 1'b1;
  assign fp_dec = (fp == '0) ? LAST : fp - 1'b1;
  assign bp_inc = (bp == LAST) ? '0 : bp + 1'b1;
  assign bp_dec = (bp == '0) ? LAST : bp - 1'b1;
  assign empty  = (cnt == '0);
  assign full   = (cnt == FULL);

  // Decode the operation against the current fill
  always_comb begin
    fp_next     = fp;
    bp_next     = bp;
    cnt_next    = cnt;
    popped_next = '0;
    stat_next   = dq_pkg::STAT_OK;
    we          = 1'b0;
    waddr       = fp;
    case (op)
      dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          stat_next = dq_pkg::STAT_FULL;
        end else if (empty) begin
          we       = 1'b1;
          waddr    = fp;
          bp_next  = fp;
          cnt_next = CW'(1);
        end else if (op == dq_pkg::OP_PUSH_BACK) begin
          we       = 1'b1;
          waddr    = bp_inc;
          bp_next  = bp_inc;
          cnt_next = cnt + 1'b1;
        end else begin
          we       = 1'b1;
          waddr    = fp_dec;
          fp_next  = fp_dec;
          cnt_next = cnt + 1'b1;
        end
      end
      dq_pkg::OP_CLEAR: begin
        fp_next  = '0;
        bp_next  = '0;
        cnt_next = '0;
      end
      dq_pkg::OP_POP_BACK: begin
        if (empty) begin
          stat_next = dq_pkg::STAT_EMPTY;
        end else begin
          popped_next = rd_b;
          cnt_next    = cnt - 1'b1;
          if (cnt != CW'(1)) begin
            bp_next = bp_dec;
          end
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          stat_next = dq_pkg::STAT_EMPTY;
        end else begin
          popped_next = rd_f;
          cnt_next    = cnt - 1'b1;
          if (cnt != CW'(1)) begin
            fp_next = fp_inc;
          end
        end
      end
      dq_pkg::OP_WRITE_BACK: begin
        if (empty) begin
          stat_next = dq_pkg::STAT_EMPTY;
        end else begin
          we    = 1'b1;
          waddr = bp;
        end
      end
      dq_pkg::OP_WRITE_FRONT: begin
        if (empty) begin
          stat_next = dq_pkg::STAT_EMPTY;
        end else begin
          we    = 1'b1;
          waddr = fp;
        end
      end
      dq_pkg::OP_PEEK: begin
        if (empty) begin
          stat_next = dq_pkg::STAT_EMPTY;
        end
      end
      default: begin
        stat_next = dq_pkg::STAT_OK;
      end
    endcase
  end

  // Update pointers and fill on execute
  always_ff @(posedge clk) begin
    if (rst) begin
      fp  <= '0;
      bp  <= '0;
      cnt <= '0;
    end else if (cmd.exec) begin
      fp  <= fp_next;
      bp  <= bp_next;
      cnt <= cnt_next;
    end
  end

  // Hold the popped word and status for the result beat
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      popped <= popped_next;
      stat   <= stat_next;
    end
  end

  // Write the ring on execute, read both ends every cycle
  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr] <= wdata;
    end
    rd_f <= mem[fp];
    rd_b <= mem[bp];
  end

  // Drive the result beat
  assign popped_value = dq_pkg::WORD_W'(popped);
  assign status       = stat;
  assign count        = dq_pkg::COUNT_W'(cnt);
  assign front_value  = empty ? '0 : dq_pkg::WORD_W'(rd_f);
  assign back_value   = empty ? '0 : dq_pkg::WORD_W'(rd_b);

endmodule

@@ rtl/double_ended_queue.sv @@
// Top level of the bounded double-ended queue on a ring store.
// An accepted beat passes through the execute and look-up states before done goes high.
// A new beat is not taken while busy; start is taken again in the result cycle, after the
// execute state and one registered read of both ring ends in the look-up state.
// Reset (rst, synchronous): pointers and fill return to zero; ring contents are kept.
// The result is shown for a single cycle and cannot be stalled by the receiver.
module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [dq_pkg::MODE_W-1:0]   mode,
  input  logic [dq_pkg::WORD_W-1:0]   value,
  output logic                        done,
  output logic [dq_pkg::WORD_W-1:0]   popped_value,
  output logic [dq_pkg::STATUS_W-1:0] status,
  output logic [dq_pkg::COUNT_W-1:0]  count,
  output logic [dq_pkg::WORD_W-1:0]   front_value,
  output logic [dq_pkg::WORD_W-1:0]   back_value
);

  dq_pkg::ctl_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .mode         (mode),
    .value        (value),
    .popped_value (popped_value),
    .status       (status),
    .count        (count),
    .front_value  (front_value),
    .back_value   (back_value)
  );

  assign done = cmd.done;

endmodule

@@ rtl/dq_checker.sv @@
// Port-level checker for the double-ended queue, bound to the top level.
module dq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [dq_pkg::WORD_W-1:0]   popped_value,
  input logic [dq_pkg::STATUS_W-1:0] status,
  input logic [dq_pkg::COUNT_W-1:0]  count,
  input logic [dq_pkg::WORD_W-1:0]   front_value,
  input logic [dq_pkg::WORD_W-1:0]   back_value
);

  // Every accepted beat yields its result beat after the execute and look-up states
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result beat missing after accepted beat");

  // No result beat while the block reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // An error or dropped push carries no popped word
  a_error_no_pop: assert property (@(posedge clk) disable iff (rst)
    (done && (status == dq_pkg::STAT_EMPTY || status == dq_pkg::STAT_FULL))
      |-> (popped_value == '0))
    else $error("popped word on failed operation");

  // An empty queue shows zero at both ends
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (done && count == '0) |-> (front_value == '0 && back_value == '0))
    else $error("nonzero end word on empty queue");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);
